@@ rtl/core/mts_pkg.sv @@
// Package for the minimum-tracking stack.
// Holds sizes, operation and status codes, the FSM state type and the result record.
// No dependencies.
`default_nettype none

package mts_pkg;

  localparam int DEPTH       = 1024;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int DEPTH_NOW_W = 11;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [DATA_W-1:0]      top_value;
    logic [DATA_W-1:0]      min_value;
    logic [DEPTH_NOW_W-1:0] depth_now;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DIFF_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/core/mts_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/mts_ctrl.sv @@
// Stack controller: entry count, current minimum, cached top difference and sequencer.
// Depends on mts_pkg; drives the difference store held in mts_ram.
`default_nettype none

module mts_ctrl
  import mts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_kind,
  input  wire logic [DATA_W-1:0] in_value,
  input  wire logic              out_room,
  output logic                   res_valid,
  output res_t                   res,
  output mem_req_t               mem_req,
  input  wire logic [DIFF_W-1:0] mem_rdata
);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] cur_min;
  logic signed [DIFF_W-1:0] top_diff;
  logic [1:0]               status;

  logic                     accept;
  logic                     is_push, is_pop;
  logic                     full, empty;
  logic signed [DIFF_W-1:0] push_diff;
  logic signed [DIFF_W-1:0] pop_min;
  logic signed [DIFF_W-1:0] top_sum;

  assign accept    = in_valid && in_ready;
  assign is_push   = (in_kind == KIND_PUSH);
  assign is_pop    = (in_kind == KIND_POP);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign push_diff = $signed({in_value[DATA_W-1], in_value}) -
                     $signed({cur_min[DATA_W-1], cur_min});
  assign pop_min   = $signed({cur_min[DATA_W-1], cur_min}) - top_diff;
  assign top_sum   = top_diff + $signed({cur_min[DATA_W-1], cur_min});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_pop && (count > CNT_W'(1))) begin
            state_next = ST_POP_WAIT;
          end else begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_POP_WAIT: state_next = ST_REPORT;
      ST_REPORT:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE) && out_room;
    res_valid = (state == ST_REPORT);
    res.status = status;
    if (empty) begin
      res.top_value = '0;
      res.min_value = '0;
      res.depth_now = '0;
    end else begin
      res.top_value = top_diff[DIFF_W-1] ? cur_min : top_sum[DATA_W-1:0];
      res.min_value = cur_min;
      res.depth_now = DEPTH_NOW_W'(count);
    end
    mem_req.we    = accept && is_push && !full;
    mem_req.waddr = count[ADDR_W-1:0];
    mem_req.wdata = empty ? '0 : push_diff;
    mem_req.raddr = ADDR_W'(count - CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      cur_min <= '0;
      status  <= STATUS_OK;
    end else begin
      state <= state_next;
      if (accept) begin
        status <= STATUS_OK;
        case (in_kind)
          KIND_PUSH: begin
            if (full) begin
              status <= STATUS_OVERFLOW;
            end else begin
              count <= count + CNT_W'(1);
              if (empty) begin
                cur_min  <= in_value;
                top_diff <= '0;
              end else begin
                top_diff <= push_diff;
                if ($signed(in_value) < cur_min) begin
                  cur_min <= in_value;
                end
              end
            end
          end
          KIND_POP: begin
            if (empty) begin
              status <= STATUS_UNDERFLOW;
            end else begin
              count <= count - CNT_W'(1);
              if (top_diff[DIFF_W-1]) begin
                cur_min <= pop_min[DATA_W-1:0];
              end
            end
          end
          default: begin
            if (empty) begin
              status <= STATUS_UNDERFLOW;
            end
          end
        endcase
      end
      if (state == ST_POP_WAIT) begin
        top_diff <= mem_rdata;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the stack depth.");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && is_push && !full |=> count == $past(count) + CNT_W'(1))
    else $error("Accepted push did not add an entry.");

  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    accept && is_pop && (count > CNT_W'(1)) |=> state == ST_POP_WAIT)
    else $error("Pop leaving entries did not fetch the new top.");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !in_ready ##1 !res_valid)
    else $error("Result reported twice or input taken during report.");

endmodule

`default_nettype wire

@@ rtl/core/min_tracking_stack.sv @@
// Top level of the minimum-tracking stack: controller, difference store and output queue.
// Depends on mts_pkg, mts_ctrl and mts_ram.
//
// Usage: each input word on the s_axis group is a push, pop or query, selected by
// s_axis_tuser; s_axis_tdata carries the signed value to push. Every word yields one
// result word on the m_axis group with the status in m_axis_tuser and the top entry,
// the minimum and the entry count in m_axis_tdata (zeros for an empty stack).
// A push or a query passes from acceptance through the report state to its result; a pop
// that leaves entries passes through a wait state first, as the new top difference is
// fetched through the registered read port of the difference store. One word is worked
// on at a time, so a new word is taken only once the last one has been reported.
// Results go into a two-word queue, so a word can be taken while a finished result
// waits; when the receiver stalls and the queue is full, s_axis_tready stays low.
// Reset clears the entry count, the minimum and the queue; the store needs no clearing,
// as only entries written by a push are ever read.
`default_nettype none

module min_tracking_stack
  import mts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // value[31:0]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // top_value[31:0], min_value[63:32],
                                          // depth_now[74:64], zeros[79:75]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  logic              res_valid;
  res_t              res;
  mem_req_t          mem_req;
  logic [DIFF_W-1:0] mem_rdata;

  res_t              queue [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        fill;
  logic              out_room;
  logic              pop_out;
  res_t              head;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_value  (s_axis_tdata),
    .out_room  (out_room),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  mts_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  assign out_room      = (fill != 2'd2);
  assign m_axis_tvalid = (fill != 2'd0);
  assign pop_out       = m_axis_tvalid && m_axis_tready;
  assign head          = queue[rd_ptr];
  assign m_axis_tuser  = head.status;
  assign m_axis_tdata  = {5'd0, head.depth_now, head.min_value, head.top_value};

  always_ff @(posedge clk) begin
    if (res_valid) begin
      queue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (res_valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_out) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, res_valid} - {1'b0, pop_out};
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fill != 2'd2) || pop_out)
    else $error("Result arrived with the output queue full.");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("Output queue fill count out of range.");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !s_axis_tready)
    else $error("Input word taken with no room for its result.");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for min_tracking_stack: drives push, pop and query words with random
// gaps and stalls, and checks every result word against a predictor of the stack.
// Depends on mts_pkg and the min_tracking_stack RTL.

module tb_top;
  import mts_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int FILL_LEVEL  = 128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    bit          drain;
  } stack_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_QUERY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  stack_op_t pending_ops[$];
  res_t      due_results[$];
  stack_op_t cur_op;

  logic signed [DIFF_W-1:0] diff_mem [DEPTH];
  logic signed [DATA_W-1:0] min_now = '0;
  int unsigned              entries = 0;

  int gen_entries = 0;
  bit drain_next = 1'b0;
  bit word_taken = 1'b0;
  bit result_taken = 1'b0;
  bit holding = 1'b0;
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  min_tracking_stack dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one word to the predicted stack and returns the result it should give.
  function automatic res_t predict_stack_op(logic [1:0] kind, logic signed [31:0] v);
    res_t                     r;
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] wide;
    r.status = STATUS_OK;
    case (kind)
      KIND_PUSH: begin
        if (entries >= DEPTH) begin
          r.status = STATUS_OVERFLOW;
        end else if (entries == 0) begin
          diff_mem[0] = '0;
          min_now = v;
          entries = 1;
        end else begin
          diff_mem[entries] = v - min_now;
          if (v < min_now) min_now = v;
          entries++;
        end
      end
      KIND_POP: begin
        if (entries == 0) begin
          r.status = STATUS_UNDERFLOW;
        end else begin
          d = diff_mem[entries - 1];
          if (d < 0) begin
            wide = min_now - d;
            min_now = wide[DATA_W-1:0];
          end
          entries--;
        end
      end
      default: begin
        if (entries == 0) r.status = STATUS_UNDERFLOW;
      end
    endcase
    if (entries == 0) begin
      r.top_value = '0;
      r.min_value = '0;
      r.depth_now = '0;
    end else begin
      d = diff_mem[entries - 1];
      wide = d + min_now;
      r.top_value = (d < 0) ? min_now : wide[DATA_W-1:0];
      r.min_value = min_now;
      r.depth_now = entries[DEPTH_NOW_W-1:0];
    end
    return r;
  endfunction

  task automatic add_op(logic [1:0] kind, logic [31:0] value);
    stack_op_t w;
    w.kind = kind;
    w.value = value;
    w.drain = drain_next;
    drain_next = 1'b0;
    pending_ops.insert(pending_ops.size(), w);
    if (kind == KIND_PUSH && gen_entries < DEPTH) gen_entries++;
    if (kind == KIND_POP && gen_entries > 0) gen_entries--;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_op(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) add_op(KIND_PUSH, pick_value());
    else if (roll < push_pct + 30) add_op(KIND_POP, $urandom);
    else if (roll < push_pct + 38) add_op(KIND_SPARE, $urandom);
    else add_op(KIND_QUERY, $urandom);
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (word_taken) begin
        word_taken = 1'b0;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && due_results.size() > 0)) begin
          cur_op = pending_ops.pop_front();
          holding = 1'b1;
          if ($urandom_range(0, 31) == 0) send_gaps = !send_gaps;
          gap_left = send_gaps ? $urandom_range(0, 15) : 0;
        end
      end
      s_axis_tvalid <= holding;
      if (holding) begin
        s_axis_tdata <= cur_op.value;
        s_axis_tuser <= cur_op.kind;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) begin
        result_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) recv_stalls = !recv_stalls;
        stall_left = recv_stalls ? $urandom_range(0, 15) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_ports
    res_t got;
    res_t want;
    bit   moved;
    moved = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.insert(due_results.size(), predict_stack_op(s_axis_tuser, s_axis_tdata));
        word_taken = 1'b1;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_taken = 1'b1;
        moved = 1'b1;
        got.status = m_axis_tuser;
        got.top_value = m_axis_tdata[31:0];
        got.min_value = m_axis_tdata[63:32];
        got.depth_now = m_axis_tdata[74:64];
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Result word with none expected: status %0d top %0d min %0d depth %0d",
                     got.status, $signed(got.top_value), $signed(got.min_value),
                     got.depth_now);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"Mismatch: expected status %0d top %0d min %0d depth %0d,",
                        " got status %0d top %0d min %0d depth %0d"},
                       want.status, $signed(want.top_value), $signed(want.min_value),
                       want.depth_now, got.status, $signed(got.top_value),
                       $signed(got.min_value), got.depth_now);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    // Empty stack, the extreme values and a pop that restores an earlier minimum.
    add_op(KIND_POP, 32'h0);
    add_op(KIND_QUERY, 32'h0);
    add_op(KIND_SPARE, 32'hffff_ffff);
    add_op(KIND_PUSH, 32'h0);
    add_op(KIND_PUSH, 32'h7fff_ffff);
    add_op(KIND_PUSH, 32'h8000_0000);
    add_op(KIND_QUERY, 32'hffff_ffff);
    add_op(KIND_POP, 32'h0);
    add_op(KIND_PUSH, 32'hffff_ffff);
    add_op(KIND_PUSH, 32'd5);
    add_op(KIND_PUSH, 32'hffff_ffff);
    add_op(KIND_SPARE, 32'h0);
    repeat (6) add_op(KIND_POP, 32'h0);
    add_op(KIND_PUSH, 32'h8000_0000);
    add_op(KIND_PUSH, 32'h7fff_ffff);
    add_op(KIND_POP, 32'h0);
    add_op(KIND_POP, 32'h0);

    drain_next = 1'b1;
    repeat (150) add_random_op(gen_entries < 8 ? 60 : 45);
    while (gen_entries < FILL_LEVEL) add_op(KIND_PUSH, pick_value());
    drain_next = 1'b1;
    repeat (3) add_op(KIND_PUSH, pick_value());
    add_op(KIND_QUERY, $urandom);
    add_op(KIND_POP, $urandom);
    add_op(KIND_PUSH, pick_value());
    add_op(KIND_PUSH, pick_value());
    drain_next = 1'b1;
    repeat (100) add_random_op(30);
    while (gen_entries > 0) add_op(KIND_POP, $urandom);
    repeat (2) add_op(KIND_POP, $urandom);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_ops.size() > 0 || holding || due_results.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mts_pkg.sv
rtl/core/mts_ram.sv
rtl/core/mts_ctrl.sv
rtl/core/min_tracking_stack.sv
bench/tb_top.sv
